// File: design/dct_pkg.sv
// Shared types and constants of the debounced countdown timer.
`timescale 1ns / 1ps

package dct_pkg;

   localparam logic [1:0] MODE_READY   = 2'd0;
   localparam logic [1:0] MODE_RUNNING = 2'd1;
   localparam logic [1:0] MODE_PAUSED  = 2'd2;
   localparam logic [1:0] MODE_DONE    = 2'd3;

   localparam logic CSR_DURATION = 1'b0;
   localparam logic CSR_DEBOUNCE = 1'b1;

   localparam logic [23:0] DURATION_RESET = 24'd10000;
   localparam logic [9:0]  DEBOUNCE_RESET = 10'd30;

   localparam int SECS_W = 15;

   // Rounding offset and reciprocal for the exact divide by 1000.
   localparam logic [24:0] ROUND_UP_MS = 25'd999;
   localparam logic [24:0] RECIP_1000  = 25'd17179870;
   localparam int          SHIFT_1000  = 34;

   // Reciprocal for the exact divide by 60.
   localparam logic [16:0] RECIP_60 = 17'd69906;
   localparam int          SHIFT_60 = 22;

   typedef struct packed {
      logic [1:0]  timer_state;
      logic [23:0] remaining_ms;
      logic        press_seen;
   } core_result_type;

   typedef struct packed {
      logic [1:0]  timer_state;
      logic [23:0] remaining_ms;
      logic        press_seen;
      logic [8:0]  display_minutes;
      logic [5:0]  display_seconds;
   } result_type;

endpackage

// File: design/dct_core.sv
// Timer state machine, button debouncer and configuration registers.
`timescale 1ns / 1ps

module dct_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [23:0]              csr_wdata,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [15:0]              in_elapsed,
   input  logic                     in_level,
   output logic                     out_valid,
   input  logic                     out_ready,
   output dct_pkg::core_result_type out_result
);
   import dct_pkg::*;

   logic [23:0] duration_ff;
   logic [9:0]  debounce_ff;
   logic [1:0]  mode_ff, mode_in;
   logic [23:0] time_ff, time_in;
   logic        raw_ff, raw_in;
   logic        stable_ff, stable_in;
   logic [15:0] since_ff, since_in;
   logic        press_in;
   logic [16:0] since_sum;
   logic        accept;
   logic        out_valid_ff;
   core_result_type out_ff;

   assign in_ready   = !out_valid_ff || out_ready;
   assign accept     = in_valid && in_ready;
   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;
   assign since_sum  = {1'b0, since_ff} + {1'b0, in_elapsed};

   always_comb begin
      mode_in   = mode_ff;
      time_in   = time_ff;
      raw_in    = raw_ff;
      stable_in = stable_ff;
      since_in  = since_ff;
      press_in  = 1'b0;
      if (accept) begin
         if (mode_ff == MODE_RUNNING) begin
            if ({8'd0, in_elapsed} >= time_ff) begin
               time_in = '0;
               mode_in = MODE_DONE;
            end else begin
               time_in = time_ff - {8'd0, in_elapsed};
            end
         end
         if (in_level != raw_ff) begin
            raw_in   = in_level;
            since_in = '0;
         end else if (since_sum[16]) begin
            since_in = 16'hFFFF;
         end else begin
            since_in = since_sum[15:0];
         end
         if (raw_in != stable_ff && since_in >= {6'd0, debounce_ff}) begin
            stable_in = raw_in;
            press_in  = !raw_in;
         end
         if (press_in) begin
            case (mode_in)
               MODE_READY, MODE_PAUSED: begin
                  mode_in = MODE_RUNNING;
               end
               MODE_RUNNING: begin
                  mode_in = MODE_PAUSED;
               end
               default: begin
                  time_in = duration_ff;
                  mode_in = MODE_READY;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= DURATION_RESET;
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DURATION: begin
               duration_ff <= csr_wdata;
            end
            CSR_DEBOUNCE: begin
               debounce_ff <= csr_wdata[9:0];
            end
            default: begin
               duration_ff <= duration_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_READY;
         time_ff      <= DURATION_RESET;
         raw_ff       <= 1'b1;
         stable_ff    <= 1'b1;
         since_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         time_ff   <= time_in;
         raw_ff    <= raw_in;
         stable_ff <= stable_in;
         since_ff  <= since_in;
         if (in_ready) begin
            out_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_ff.timer_state  <= mode_in;
         out_ff.remaining_ms <= time_in;
         out_ff.press_seen   <= press_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_result_tracks_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.timer_state == mode_ff && out_ff.remaining_ms == time_ff))
      else $error("held result does not match the timer state");

   a_press_means_low: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.press_seen) |-> !stable_ff)
      else $error("press reported while the debounced level is released");

   a_done_at_zero: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_DONE) |-> (time_ff == '0))
      else $error("timer done with time left");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(since_ff) && $stable(mode_ff) && $stable(time_ff)))
      else $error("timer state changed without an item");
`endif

endmodule

// File: design/dct_display.sv
// Two-stage conversion of the remaining time into minutes and rounded-up seconds.
`timescale 1ns / 1ps

module dct_display (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  dct_pkg::core_result_type in_result,
   output logic                     out_valid,
   input  logic                     out_ready,
   output dct_pkg::result_type      out_result
);
   import dct_pkg::*;

   logic [24:0]       round_ms;
   logic [49:0]       secs_prod;
   logic              mid_valid_ff;
   logic              mid_ready;
   core_result_type   mid_ff;
   logic [SECS_W-1:0] secs_ff;
   logic [31:0]       mins_prod;
   logic [8:0]        mins;
   logic [SECS_W-1:0] mins_x60;
   logic [SECS_W-1:0] secs_left;
   logic              out_valid_ff;
   result_type        out_ff;

   assign round_ms  = {1'b0, in_result.remaining_ms} + ROUND_UP_MS;
   assign secs_prod = round_ms * RECIP_1000;

   assign mid_ready = !out_valid_ff || out_ready;
   assign in_ready  = !mid_valid_ff || mid_ready;

   assign mins_prod = {2'd0, secs_ff} * {15'd0, RECIP_60};
   assign mins      = mins_prod[SHIFT_60 +: 9];
   assign mins_x60  = {mins, 6'd0} - {4'd0, mins, 2'd0};
   assign secs_left = secs_ff - mins_x60;

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            mid_valid_ff <= in_valid;
         end
         if (mid_ready) begin
            out_valid_ff <= mid_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         mid_ff  <= in_result;
         secs_ff <= secs_prod[SHIFT_1000 +: SECS_W];
      end
      if (mid_valid_ff && mid_ready) begin
         out_ff.timer_state     <= mid_ff.timer_state;
         out_ff.remaining_ms    <= mid_ff.remaining_ms;
         out_ff.press_seen      <= mid_ff.press_seen;
         out_ff.display_minutes <= mins;
         out_ff.display_seconds <= secs_left[5:0];
      end
   end

endmodule

// File: design/debounced_countdown_timer.sv
// Top level of the countdown timer with a debounced start and pause button.
`timescale 1ns / 1ps

// Each request item is one tick: the milliseconds since the previous tick and the raw,
// active-low button level. The block takes one item every clock cycle while the response
// side keeps up, and returns one response item for each, in order, after it has passed
// the input register, the timer and debouncer update, and the display conversion,
// whose two constant-reciprocal multiplies each end in a register. Each stage holds its
// item while the next is full; while a finished response waits, items enter until all are full.
// The configuration port writes the duration and the debounce time; write it only while
// no item is in flight. A new duration takes effect at the next reload from done.
module debounced_countdown_timer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // elapsed_ms[15:0], button_level[16], zeros above
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // timer_state[1:0], remaining_ms[25:2], press_seen[26],
                                    // display_minutes[35:27], display_seconds[41:36], zeros
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [23:0] csr_wdata
);
   import dct_pkg::*;

   logic            in_valid_ff;
   logic [15:0]     in_elapsed_ff;
   logic            in_level_ff;
   logic            core_ready;
   logic            core_valid;
   logic            disp_ready;
   core_result_type core_result;
   result_type      rsp_result;

   assign req_tready = !in_valid_ff || core_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_elapsed_ff <= req_tdata[15:0];
         in_level_ff   <= req_tdata[16];
      end
   end

   dct_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_valid   (in_valid_ff),
      .in_ready   (core_ready),
      .in_elapsed (in_elapsed_ff),
      .in_level   (in_level_ff),
      .out_valid  (core_valid),
      .out_ready  (disp_ready),
      .out_result (core_result)
   );

   dct_display u_display (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (core_valid),
      .in_ready   (disp_ready),
      .in_result  (core_result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_result)
   );

   assign rsp_tdata = {6'd0,
                       rsp_result.display_seconds,
                       rsp_result.display_minutes,
                       rsp_result.press_seen,
                       rsp_result.remaining_ms,
                       rsp_result.timer_state};

endmodule

// File: sim/tb_debounced_countdown_timer.sv
// Self-checking testbench for the debounced countdown timer: directed table, random ticks.
`timescale 1ns / 1ps

module tb_debounced_countdown_timer;
   import dct_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // elapsed_ms[15:0], button_level[16], zeros above
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // timer_state[1:0], remaining_ms[25:2], press_seen[26],
                             // display_minutes[35:27], display_seconds[41:36], zeros
   logic        csr_we;
   logic        csr_index;
   logic [23:0] csr_wdata;

   typedef struct {
      logic        is_cfg;
      logic        csr_sel;
      logic [23:0] csr_val;
      logic [15:0] elapsed;
      logic        level;
      logic        has_lit;
      result_type  lit;
   } dir_row_type;

   logic [1:0]  pred_mode;
   logic [23:0] pred_left;
   logic        pred_raw;
   logic        pred_stable;
   logic [15:0] pred_since;
   logic [23:0] cfg_duration;
   logic [9:0]  cfg_debounce;

   result_type  readouts_due[$];
   dir_row_type dir_table[$];
   int          failures;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          holds_requested;
   int          holds_served;
   int          hold_left;
   logic        gen_level;

   debounced_countdown_timer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic result_type advance_timer(input logic [15:0] elapsed, input logic level);
      result_type  r;
      logic        press;
      int unsigned sum;
      int unsigned secs;
      if (pred_mode == MODE_RUNNING) begin
         if (elapsed >= pred_left) begin
            pred_left = '0;
            pred_mode = MODE_DONE;
         end else begin
            pred_left = pred_left - elapsed;
         end
      end
      if (level != pred_raw) begin
         pred_raw   = level;
         pred_since = '0;
      end else begin
         sum        = pred_since + elapsed;
         pred_since = (sum > 32'hFFFF) ? 16'hFFFF : sum[15:0];
      end
      press = 1'b0;
      if (pred_raw != pred_stable && pred_since >= cfg_debounce) begin
         pred_stable = pred_raw;
         press       = (pred_stable == 1'b0);
      end
      if (press) begin
         case (pred_mode)
            MODE_READY, MODE_PAUSED: pred_mode = MODE_RUNNING;
            MODE_RUNNING: pred_mode = MODE_PAUSED;
            default: begin
               pred_left = cfg_duration;
               pred_mode = MODE_READY;
            end
         endcase
      end
      secs              = (pred_left + 999) / 1000;
      r.timer_state     = pred_mode;
      r.remaining_ms    = pred_left;
      r.press_seen      = press;
      r.display_minutes = 9'(secs / 60);
      r.display_seconds = 6'(secs % 60);
      return r;
   endfunction

   function automatic dir_row_type tick_row(input logic [15:0] elapsed, input logic level);
      dir_row_type row;
      row         = '{default: '0};
      row.elapsed = elapsed;
      row.level   = level;
      return row;
   endfunction

   function automatic dir_row_type lit_row(input logic [15:0] elapsed, input logic level,
                                           input result_type lit);
      dir_row_type row;
      row         = tick_row(elapsed, level);
      row.has_lit = 1'b1;
      row.lit     = lit;
      return row;
   endfunction

   function automatic dir_row_type cfg_row(input logic sel, input logic [23:0] val);
      dir_row_type row;
      row         = '{default: '0};
      row.is_cfg  = 1'b1;
      row.csr_sel = sel;
      row.csr_val = val;
      return row;
   endfunction

   function automatic logic [15:0] pick_elapsed();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'd0;
      if (r < 15) return 16'hFFFF;
      if (r < 35) return 16'($urandom);
      return 16'($urandom_range(0, 2 * cfg_debounce + 50));
   endfunction

   task automatic send_tick(input logic [15:0] elapsed, input logic level,
                            input logic has_lit, input result_type lit);
      result_type want;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, level, elapsed};
      do @(posedge clock); while (!req_tready);
      want = advance_timer(elapsed, level);
      readouts_due.push_back(has_lit ? lit : want);
   endtask

   task automatic drain_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (readouts_due.size() == 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_register(input logic sel, input logic [23:0] val);
      drain_block();
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (sel == CSR_DURATION) cfg_duration = val;
      else cfg_debounce = val[9:0];
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (holds_requested != holds_served) begin
            holds_served++;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_readouts
      result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (readouts_due.size() == 0) begin
            $error("item received with no expectation waiting");
            failures++;
         end else begin
            want = readouts_due.pop_front();
            check_field("timer_state", want.timer_state, rsp_tdata[1:0]);
            check_field("remaining_ms", want.remaining_ms, rsp_tdata[25:2]);
            check_field("press_seen", want.press_seen, rsp_tdata[26]);
            check_field("display_minutes", want.display_minutes, rsp_tdata[35:27]);
            check_field("display_seconds", want.display_seconds, rsp_tdata[41:36]);
         end
      end
   end

   initial begin : stimulus
      logic [23:0] phase_dur[6];
      logic [9:0]  phase_deb[6];
      int          p;
      int          count;
      int          burst;
      int          k;
      logic        bounce;
      logic [15:0] el;

      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      csr_we          = 1'b0;
      csr_index       = CSR_DURATION;
      csr_wdata       = '0;
      failures        = 0;
      holds_requested = 0;
      holds_served    = 0;
      send_idle_pct   = 18;
      recv_idle_pct   = 72;
      gen_level       = 1'b1;
      pred_mode       = MODE_READY;
      pred_left       = 24'd10000;
      pred_raw        = 1'b1;
      pred_stable     = 1'b1;
      pred_since      = '0;
      cfg_duration    = 24'd10000;
      cfg_debounce    = 10'd30;

      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Press, release, bounce, pause, resume, overshoot to done, reload.
      dir_table.push_back(lit_row(16'd0, 1'b1, '{MODE_READY, 24'd10000, 1'b0, 9'd0, 6'd10}));
      dir_table.push_back(lit_row(16'hFFFF, 1'b1, '{MODE_READY, 24'd10000, 1'b0, 9'd0, 6'd10}));
      dir_table.push_back(lit_row(16'd0, 1'b0, '{MODE_READY, 24'd10000, 1'b0, 9'd0, 6'd10}));
      dir_table.push_back(lit_row(16'd30, 1'b0, '{MODE_RUNNING, 24'd10000, 1'b1, 9'd0, 6'd10}));
      dir_table.push_back(tick_row(16'd1, 1'b0));
      dir_table.push_back(tick_row(16'd0, 1'b1));
      dir_table.push_back(tick_row(16'd40, 1'b1));
      dir_table.push_back(tick_row(16'd5, 1'b0));
      dir_table.push_back(tick_row(16'd10, 1'b1));
      dir_table.push_back(tick_row(16'd10, 1'b0));
      dir_table.push_back(tick_row(16'd30, 1'b0));
      dir_table.push_back(tick_row(16'd0, 1'b1));
      dir_table.push_back(tick_row(16'd30, 1'b1));
      dir_table.push_back(tick_row(16'd0, 1'b0));
      dir_table.push_back(tick_row(16'd30, 1'b0));
      dir_table.push_back(lit_row(16'hFFFF, 1'b0, '{MODE_DONE, 24'd0, 1'b0, 9'd0, 6'd0}));
      dir_table.push_back(tick_row(16'd0, 1'b1));
      dir_table.push_back(tick_row(16'd30, 1'b1));
      dir_table.push_back(tick_row(16'd0, 1'b0));
      dir_table.push_back(lit_row(16'd30, 1'b0, '{MODE_READY, 24'd10000, 1'b1, 9'd0, 6'd10}));
      // Zero debounce and zero duration; elapsed equal to the time left.
      dir_table.push_back(cfg_row(CSR_DURATION, 24'd0));
      dir_table.push_back(cfg_row(CSR_DEBOUNCE, 24'd0));
      dir_table.push_back(tick_row(16'd0, 1'b1));
      dir_table.push_back(lit_row(16'd0, 1'b0, '{MODE_RUNNING, 24'd10000, 1'b1, 9'd0, 6'd10}));
      dir_table.push_back(lit_row(16'd10000, 1'b0, '{MODE_DONE, 24'd0, 1'b0, 9'd0, 6'd0}));
      dir_table.push_back(tick_row(16'd0, 1'b1));
      dir_table.push_back(lit_row(16'd0, 1'b0, '{MODE_READY, 24'd0, 1'b1, 9'd0, 6'd0}));
      dir_table.push_back(tick_row(16'd0, 1'b1));
      dir_table.push_back(lit_row(16'd0, 1'b0, '{MODE_RUNNING, 24'd0, 1'b1, 9'd0, 6'd0}));
      dir_table.push_back(lit_row(16'd0, 1'b1, '{MODE_DONE, 24'd0, 1'b0, 9'd0, 6'd0}));
      // Rounding of the seconds shown.
      dir_table.push_back(cfg_row(CSR_DURATION, 24'd1001));
      dir_table.push_back(tick_row(16'd0, 1'b0));
      dir_table.push_back(tick_row(16'd0, 1'b1));
      dir_table.push_back(tick_row(16'd0, 1'b0));
      dir_table.push_back(tick_row(16'd999, 1'b0));

      foreach (dir_table[i]) begin
         if (dir_table[i].is_cfg)
            write_register(dir_table[i].csr_sel, dir_table[i].csr_val);
         else
            send_tick(dir_table[i].elapsed, dir_table[i].level,
                      dir_table[i].has_lit, dir_table[i].lit);
      end

      phase_dur = '{24'd1, 24'hFFFFFF, 24'd10000, 24'd2500,
                    24'($urandom_range(1, 24'hFFFFFF)), 24'd60000};
      phase_deb = '{10'd0, 10'h3FF, 10'd30, 10'd5, 10'($urandom), 10'h3FF};

      for (p = 0; p < 6; p++) begin
         write_register(CSR_DURATION, phase_dur[p]);
         write_register(CSR_DEBOUNCE, {14'd0, phase_deb[p]});
         if (p < 2) begin
            send_idle_pct = 18;
            recv_idle_pct = 72;
         end else if (p < 4) begin
            send_idle_pct = 72;
            recv_idle_pct = 18;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         count = 0;
         while (count < 325) begin
            if (p == 4 && count >= 50 && holds_requested == 0) holds_requested++;
            if (p == 2 && count >= 150 && count < 156) begin
               drain_block();
               count = 156;
            end
            burst  = $urandom_range(1, 6);
            bounce = ($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 99) < 80) gen_level = ~gen_level;
            else gen_level = 1'($urandom_range(0, 1));
            for (k = 0; k < burst; k++) begin
               if (bounce) el = 16'($urandom_range(0, cfg_debounce / 4));
               else el = pick_elapsed();
               send_tick(el, gen_level, 1'b0, '0);
               count++;
            end
         end
      end

      drain_block();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
